// ===== sv/spr_pkg.sv =====
// ----------------------------------------------------------------------------
// spr_pkg
// Shared constants, codes and types of the slotted page record store.
// ----------------------------------------------------------------------------
package spr_pkg;

    // Page geometry
    localparam int PAGE_BYTES_DEF  = 4096;
    localparam int MAX_ENTRIES_DEF = 512;
    localparam int HEADER_BYTES    = 8;
    localparam int ENTRY_BYTES     = 6;

    // Field widths of the command and result words
    localparam int CMD_W    = 2;
    localparam int SLOT_W   = 10;
    localparam int LEN_W    = 12;
    localparam int BYTE_W   = 8;
    localparam int POS_W    = 12;
    localparam int STAT_W   = 3;
    localparam int ASSIGN_W = 9;
    localparam int FREE_W   = 12;
    localparam int USED_W   = 10;
    localparam int PAGE_NUM_W = 32;

    // Insert progress counter saturates at its all-ones value
    localparam int PROG_W = 13;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd3;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_NO_ROOM  = 3'd1;
    localparam logic [STAT_W-1:0] ST_INVALID  = 3'd2;
    localparam logic [STAT_W-1:0] ST_INACTIVE = 3'd3;
    localparam logic [STAT_W-1:0] ST_DELETED  = 3'd4;

    // Dump address split: (pos - HEADER_BYTES) / ENTRY_BYTES by reciprocal.
    // Exact for POS_W-bit values since the rounding error stays below
    // 2**(DIV_SHIFT - POS_W).
    localparam int DIV_SHIFT = POS_W + 4;
    localparam int DIV_MULT  = (2**DIV_SHIFT + ENTRY_BYTES - 1) / ENTRY_BYTES;
    localparam int DIV_MW    = DIV_SHIFT + 1;
    localparam int PROD_W    = POS_W + DIV_MW;
    localparam int IDX_W     = PROD_W - DIV_SHIFT;
    localparam int SUB_W     = 3;

    typedef struct packed {
        logic [IDX_W-1:0] idx;   // directory entry the dump address falls in
        logic [SUB_W-1:0] sub;   // byte within that entry
    } t_dump_loc;

endpackage

// ===== sv/spr_if.sv =====
// ----------------------------------------------------------------------------
// spr_cmd_if / spr_res_if
// Valid/ready channels carrying command words and result words.
// ----------------------------------------------------------------------------
interface spr_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [spr_pkg::CMD_W-1:0]     command;
    logic [spr_pkg::SLOT_W-1:0]    slot_number;
    logic [spr_pkg::LEN_W-1:0]     record_length;
    logic [spr_pkg::BYTE_W-1:0]    data_byte;
    logic                          last_byte;
    logic [spr_pkg::POS_W-1:0]     byte_position;

    modport source (output valid, command, slot_number, record_length, data_byte,
                    last_byte, byte_position, input ready);
    modport sink   (input valid, command, slot_number, record_length, data_byte,
                    last_byte, byte_position, output ready);
endinterface

interface spr_res_if;
    logic                          valid;
    logic                          ready;
    logic [spr_pkg::STAT_W-1:0]    status;
    logic [spr_pkg::ASSIGN_W-1:0]  slot_assigned;
    logic [spr_pkg::BYTE_W-1:0]    byte_out;
    logic                          end_flag;
    logic [spr_pkg::FREE_W-1:0]    free_bytes;
    logic [spr_pkg::USED_W-1:0]    slots_used;

    modport source (output valid, status, slot_assigned, byte_out, end_flag,
                    free_bytes, slots_used, input ready);
    modport sink   (input valid, status, slot_assigned, byte_out, end_flag,
                    free_bytes, slots_used, output ready);
endinterface

// ===== sv/spr_ram.sv =====
// ----------------------------------------------------------------------------
// spr_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module spr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/spr_addr_div.sv =====
// ----------------------------------------------------------------------------
// spr_addr_div
// Splits a dump address past the header into directory entry and byte.
// ----------------------------------------------------------------------------
module spr_addr_div (
    input  logic                       i_clk,
    input  logic                       i_load,
    input  logic [spr_pkg::POS_W-1:0]  i_pos,
    output spr_pkg::t_dump_loc         o_loc
);

    localparam logic [spr_pkg::DIV_MW-1:0] MULT = spr_pkg::DIV_MULT[spr_pkg::DIV_MW-1:0];

    logic [spr_pkg::POS_W-1:0]  w_rel;
    logic [spr_pkg::PROD_W-1:0] w_prod;
    logic [spr_pkg::POS_W-1:0]  r_rel;
    logic [spr_pkg::PROD_W-1:0] r_prod;
    logic [spr_pkg::IDX_W-1:0]  w_idx;
    logic [spr_pkg::PROD_W-1:0] w_base;
    logic [spr_pkg::PROD_W-1:0] w_rem;

    // Offset past the header; wraps for header addresses, which are unused
    assign w_rel  = i_pos - spr_pkg::POS_W'(spr_pkg::HEADER_BYTES);
    assign w_prod = spr_pkg::PROD_W'(w_rel) * spr_pkg::PROD_W'(MULT);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rel  <= w_rel;
            r_prod <= w_prod;
        end
    end

    assign w_idx  = r_prod[spr_pkg::PROD_W-1:spr_pkg::DIV_SHIFT];
    assign w_base = spr_pkg::PROD_W'(w_idx) * spr_pkg::PROD_W'(spr_pkg::ENTRY_BYTES);
    assign w_rem  = spr_pkg::PROD_W'(r_rel) - w_base;

    assign o_loc.idx = w_idx;
    assign o_loc.sub = w_rem[spr_pkg::SUB_W-1:0];

endmodule

// ===== sv/slotted_page_record_store.sv =====
// ----------------------------------------------------------------------------
// slotted_page_record_store
// Slotted database page in on-chip RAM: streamed record insert, record byte
// read, slot delete and serialized page dump.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake            Word
//  i_cmd     in   valid/ready          command, slot, length, data, last, position
//  o_res     out  valid/ready          status, slot, byte, end, free bytes, slots used
//  i_cfg_*   in   write enable only    page_number (32 bits)
//
//  Steps: an insert byte without the last mark stays in S_IDLE; a last byte goes
//  to S_EMIT. A read or delete of a slot past the directory end goes to S_EMIT;
//  else read passes S_ENT (directory RAM read), then S_PAGE (page RAM read) for
//  a byte in the record; delete passes S_ENT; dump passes S_DDIV (address split),
//  then, for a page byte past the header, S_ENT or S_PAGE (one RAM read).
//  Reset: after i_rst_n the page RAM is swept to zero, one byte a cycle, over
//  all PAGE_BYTES bytes, while i_cmd.ready stays low.
//  Stalls: one command is in work at a time; a command is taken while an
//  earlier result still sits in the output register, and its own result
//  waits until that register frees.
//
module slotted_page_record_store #(
    parameter int PAGE_BYTES  = spr_pkg::PAGE_BYTES_DEF,
    parameter int MAX_ENTRIES = spr_pkg::MAX_ENTRIES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [spr_pkg::PAGE_NUM_W-1:0]  i_cfg_wr_data,
    spr_cmd_if.sink                         i_cmd,
    spr_res_if.source                       o_res
);

    // Page address, free offset, slot index and entry count widths
    localparam int AW  = $clog2(PAGE_BYTES);
    localparam int OW  = $clog2(PAGE_BYTES + 1);
    localparam int IW  = $clog2(MAX_ENTRIES);
    localparam int CW  = $clog2(MAX_ENTRIES + 1);
    // Directory end, up to one entry past a full directory
    localparam int DW  = $clog2(spr_pkg::HEADER_BYTES
                                + (MAX_ENTRIES + 1) * spr_pkg::ENTRY_BYTES + 1);
    localparam int BW0 = (OW > DW) ? OW : DW;
    // Common width for fit arithmetic, wide enough for length and progress
    localparam int SW  = ((BW0 > spr_pkg::PROG_W) ? BW0 : spr_pkg::PROG_W) + 1;
    // Directory entry word: active mark, length, offset
    localparam int EW  = 1 + spr_pkg::LEN_W + OW;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_DDIV  = 6'b000100,
        S_ENT   = 6'b001000,
        S_PAGE  = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // Page state
    logic [AW-1:0]                    r_clr_addr, n_clr_addr;
    logic [spr_pkg::PAGE_NUM_W-1:0]   r_page_number;
    logic [CW-1:0]                    r_count, n_count;
    logic [DW-1:0]                    r_dir_end, n_dir_end;
    logic [OW-1:0]                    r_free, n_free;
    logic [spr_pkg::PROG_W-1:0]       r_progress, n_progress;
    logic                             r_rejected, n_rejected;

    // Command in work
    logic [spr_pkg::CMD_W-1:0]        r_cmd, n_cmd;
    logic [spr_pkg::SLOT_W-1:0]       r_slot, n_slot;
    logic [spr_pkg::POS_W-1:0]        r_pos, n_pos;
    logic [spr_pkg::SUB_W-1:0]        r_sub, n_sub;

    // Result being built
    logic [spr_pkg::STAT_W-1:0]       r_res_status, n_res_status;
    logic [spr_pkg::ASSIGN_W-1:0]     r_res_slot, n_res_slot;
    logic [spr_pkg::BYTE_W-1:0]       r_res_byte, n_res_byte;
    logic                             r_res_end, n_res_end;

    // Output register
    logic                             r_out_valid, n_out_valid;
    logic [spr_pkg::STAT_W-1:0]       r_out_status, n_out_status;
    logic [spr_pkg::ASSIGN_W-1:0]     r_out_slot, n_out_slot;
    logic [spr_pkg::BYTE_W-1:0]       r_out_byte, n_out_byte;
    logic                             r_out_end, n_out_end;
    logic [spr_pkg::FREE_W-1:0]       r_out_free, n_out_free;
    logic [spr_pkg::USED_W-1:0]       r_out_used, n_out_used;

    // Page RAM ports
    logic                             pg_we, pg_re;
    logic [AW-1:0]                    pg_waddr, pg_raddr;
    logic [spr_pkg::BYTE_W-1:0]       pg_wdata, pg_rdata;

    // Directory RAM ports
    logic                             ent_we, ent_re;
    logic [IW-1:0]                    ent_waddr, ent_raddr;
    logic [EW-1:0]                    ent_wdata, ent_rdata;

    // Dump address split
    logic                             div_load;
    spr_pkg::t_dump_loc               div_loc;

    // Insert arithmetic
    logic [SW-1:0]                    w_free_s, w_len_s, w_prog_s, w_dend_s, w_dend_next;
    logic [SW-1:0]                    w_new_ofs, w_ins_addr, w_space;
    logic [31:0]                      w_ins_addr32;
    logic                             w_fits, w_rej, w_ins_wr, w_commit;

    // Read and dump helpers
    logic                             e_act;
    logic [spr_pkg::LEN_W-1:0]        e_len;
    logic [OW-1:0]                    e_ofs;
    logic [SW-1:0]                    w_rd_addr;
    logic [31:0]                      w_rd_addr32, w_ofs32, w_len32, w_free32, w_cnt32;
    logic [31:0]                      w_slot32, w_idx32, w_pos32;
    logic [63:0]                      w_hdr;
    logic [39:0]                      w_ent_img;
    logic [63:0]                      w_hdr_sh;
    logic [39:0]                      w_ent_sh;
    logic                             w_rd_last;

    spr_ram #(
        .WIDTH (spr_pkg::BYTE_W),
        .DEPTH (PAGE_BYTES)
    ) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (pg_we),
        .i_waddr (pg_waddr),
        .i_wdata (pg_wdata),
        .i_re    (pg_re),
        .i_raddr (pg_raddr),
        .o_rdata (pg_rdata)
    );

    spr_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ENTRIES)
    ) u_dir_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_re    (ent_re),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    spr_addr_div u_addr_div (
        .i_clk  (i_clk),
        .i_load (div_load),
        .i_pos  (i_cmd.byte_position),
        .o_loc  (div_loc)
    );

    // ---- Fit check and insert address, from the incoming word ----
    assign w_free_s    = SW'(r_free);
    assign w_len_s     = SW'(i_cmd.record_length);
    assign w_prog_s    = SW'(r_progress);
    assign w_dend_s    = SW'(r_dir_end);
    assign w_dend_next = w_dend_s + SW'(spr_pkg::ENTRY_BYTES);
    assign w_new_ofs   = w_free_s - w_len_s;
    assign w_ins_addr  = w_new_ofs + w_prog_s;
    assign w_ins_addr32 = 32'(w_ins_addr);

    // Record plus one more directory entry must fit; an exact fit passes
    assign w_fits   = (r_count < CW'(MAX_ENTRIES)) && (w_len_s <= w_free_s)
                      && (w_new_ofs >= w_dend_next);
    // Reject is decided on the first byte and held for the rest of the record
    assign w_rej    = r_rejected || ((r_progress == '0) && !w_fits);
    assign w_ins_wr = !w_rej && (w_prog_s < w_len_s) && (w_len_s <= w_free_s)
                      && (w_ins_addr32 < 32'(PAGE_BYTES));
    assign w_commit = !w_rej && w_fits;

    // Free space between directory end and lowest record
    assign w_space = (w_free_s >= w_dend_s) ? (w_free_s - w_dend_s) : '0;

    // ---- Directory entry fields as read ----
    assign e_act = ent_rdata[EW-1];
    assign e_len = ent_rdata[OW +: spr_pkg::LEN_W];
    assign e_ofs = ent_rdata[OW-1:0];

    assign w_rd_addr   = SW'(e_ofs) + SW'(r_pos);
    assign w_rd_addr32 = 32'(w_rd_addr);
    assign w_rd_last   = ((spr_pkg::LEN_W + 1)'(r_pos) + (spr_pkg::LEN_W + 1)'(1))
                         == (spr_pkg::LEN_W + 1)'(e_len);

    // ---- Serialized image pieces, little-endian ----
    assign w_ofs32  = 32'(e_ofs);
    assign w_len32  = 32'(e_len);
    assign w_free32 = 32'(r_free);
    assign w_cnt32  = 32'(r_count);
    assign w_slot32 = 32'(r_slot);
    assign w_idx32  = 32'(div_loc.idx);
    assign w_pos32  = 32'(r_pos);

    assign w_hdr     = {w_free32[15:0], w_cnt32[15:0], r_page_number};
    assign w_hdr_sh  = w_hdr >> {r_pos[2:0], 3'b000};
    assign w_ent_img = {7'b0, e_act, w_len32[15:0], w_ofs32[15:0]};
    assign w_ent_sh  = w_ent_img >> {r_sub, 3'b000};

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_count      = r_count;
        n_dir_end    = r_dir_end;
        n_free       = r_free;
        n_progress   = r_progress;
        n_rejected   = r_rejected;
        n_cmd        = r_cmd;
        n_slot       = r_slot;
        n_pos        = r_pos;
        n_sub        = r_sub;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_res_byte   = r_res_byte;
        n_res_end    = r_res_end;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        n_out_byte   = r_out_byte;
        n_out_end    = r_out_end;
        n_out_free   = r_out_free;
        n_out_used   = r_out_used;

        pg_we     = 1'b0;
        pg_waddr  = w_ins_addr[AW-1:0];
        pg_wdata  = i_cmd.data_byte;
        pg_re     = 1'b0;
        pg_raddr  = w_pos32[AW-1:0];
        ent_we    = 1'b0;
        ent_waddr = w_cnt32[IW-1:0];
        ent_wdata = {1'b1, i_cmd.record_length, w_new_ofs[OW-1:0]};
        ent_re    = 1'b0;
        ent_raddr = w_idx32[IW-1:0];
        div_load  = 1'b0;

        // Drop the output word once taken
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                // Sweep the page RAM to zero
                pg_we      = 1'b1;
                pg_waddr   = r_clr_addr;
                pg_wdata   = '0;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(PAGE_BYTES - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_cmd        = i_cmd.command;
                    n_slot       = i_cmd.slot_number;
                    n_pos        = i_cmd.byte_position;
                    n_res_status = spr_pkg::ST_OK;
                    n_res_slot   = '0;
                    n_res_byte   = '0;
                    n_res_end    = 1'b0;
                    case (i_cmd.command)
                        spr_pkg::CMD_INSERT: begin
                            pg_we = w_ins_wr;
                            if (!i_cmd.last_byte) begin
                                // Advance within the record, saturating
                                n_rejected = w_rej;
                                if (r_progress != '1) begin
                                    n_progress = r_progress + spr_pkg::PROG_W'(1);
                                end
                            end else begin
                                // Commit the directory entry, or report no room
                                if (w_commit) begin
                                    ent_we     = 1'b1;
                                    n_res_slot = w_cnt32[spr_pkg::ASSIGN_W-1:0];
                                    n_count    = r_count + CW'(1);
                                    n_dir_end  = r_dir_end + DW'(spr_pkg::ENTRY_BYTES);
                                    n_free     = w_new_ofs[OW-1:0];
                                end else begin
                                    n_res_status = spr_pkg::ST_NO_ROOM;
                                end
                                n_progress = '0;
                                n_rejected = 1'b0;
                                n_state    = S_EMIT;
                            end
                        end
                        spr_pkg::CMD_READ, spr_pkg::CMD_DELETE: begin
                            if (32'(i_cmd.slot_number) >= w_cnt32) begin
                                n_res_status = spr_pkg::ST_INVALID;
                                n_state      = S_EMIT;
                            end else begin
                                ent_re    = 1'b1;
                                ent_raddr = i_cmd.slot_number[IW-1:0];
                                n_state   = S_ENT;
                            end
                        end
                        spr_pkg::CMD_DUMP: begin
                            div_load = 1'b1;
                            n_state  = S_DDIV;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_DDIV: begin
                if (w_pos32 >= 32'(PAGE_BYTES)) begin
                    n_state = S_EMIT;
                end else if (w_pos32 < 32'(spr_pkg::HEADER_BYTES)) begin
                    n_res_byte = w_hdr_sh[7:0];
                    n_state    = S_EMIT;
                end else if (w_idx32 < w_cnt32) begin
                    // Directory byte: fetch the entry
                    ent_re    = 1'b1;
                    ent_raddr = w_idx32[IW-1:0];
                    n_sub     = div_loc.sub;
                    n_state   = S_ENT;
                end else begin
                    pg_re    = 1'b1;
                    pg_raddr = w_pos32[AW-1:0];
                    n_state  = S_PAGE;
                end
            end

            S_ENT: begin
                n_state = S_EMIT;
                case (r_cmd)
                    spr_pkg::CMD_READ: begin
                        if (!e_act) begin
                            n_res_status = spr_pkg::ST_INACTIVE;
                        end else if (SW'(r_pos) >= SW'(e_len)) begin
                            n_res_end = 1'b1;
                        end else begin
                            n_res_end = w_rd_last;
                            if (w_rd_addr32 < 32'(PAGE_BYTES)) begin
                                pg_re    = 1'b1;
                                pg_raddr = w_rd_addr[AW-1:0];
                                n_state  = S_PAGE;
                            end
                        end
                    end
                    spr_pkg::CMD_DELETE: begin
                        if (!e_act) begin
                            n_res_status = spr_pkg::ST_DELETED;
                        end else begin
                            // Clear the active mark, keep offset and length
                            ent_we    = 1'b1;
                            ent_waddr = w_slot32[IW-1:0];
                            ent_wdata = {1'b0, ent_rdata[EW-2:0]};
                        end
                    end
                    spr_pkg::CMD_DUMP: begin
                        if (r_sub < spr_pkg::SUB_W'(5)) begin
                            n_res_byte = w_ent_sh[7:0];
                        end
                    end
                    default: begin
                        n_state = S_EMIT;
                    end
                endcase
            end

            S_PAGE: begin
                n_res_byte = pg_rdata;
                n_state    = S_EMIT;
            end

            S_EMIT: begin
                // Hold until the output register is free
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_slot   = r_res_slot;
                    n_out_byte   = r_res_byte;
                    n_out_end    = r_res_end;
                    n_out_free   = w_space[spr_pkg::FREE_W-1:0];
                    n_out_used   = w_cnt32[spr_pkg::USED_W-1:0];
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_addr    <= '0;
            r_page_number <= '0;
            r_count       <= '0;
            r_dir_end     <= DW'(spr_pkg::HEADER_BYTES);
            r_free        <= OW'(PAGE_BYTES);
            r_progress    <= '0;
            r_rejected    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_count     <= n_count;
            r_dir_end   <= n_dir_end;
            r_free      <= n_free;
            r_progress  <= n_progress;
            r_rejected  <= n_rejected;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_page_number <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_slot       <= n_slot;
        r_pos        <= n_pos;
        r_sub        <= n_sub;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_res_byte   <= n_res_byte;
        r_res_end    <= n_res_end;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
        r_out_byte   <= n_out_byte;
        r_out_end    <= n_out_end;
        r_out_free   <= n_out_free;
        r_out_used   <= n_out_used;
    end

    assign i_cmd.ready         = (r_state == S_IDLE);
    assign o_res.valid         = r_out_valid;
    assign o_res.status        = r_out_status;
    assign o_res.slot_assigned = r_out_slot;
    assign o_res.byte_out      = r_out_byte;
    assign o_res.end_flag      = r_out_end;
    assign o_res.free_bytes    = r_out_free;
    assign o_res.slots_used    = r_out_used;

endmodule
